// ===== rtl/core/telemetry_frame_decoder_defines.svh =====
// assertion macros shared by the telemetry frame decoder modules
`ifndef TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define TELEMETRY_FRAME_DECODER_DEFINES_SVH

// expression must hold at every clock edge outside reset
`define TFD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tfd_pkg.sv =====
// types and constants of the telemetry frame decoder
`default_nettype none
package tfd_pkg;

    localparam int PAYLOAD_LEN   = 24;
    localparam int PAYLOAD_BITS  = PAYLOAD_LEN * 8;
    localparam int FIELD_COUNT   = 14;
    localparam int QUEUE_DEPTH   = 2;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 40;
    localparam int VALUE_W       = 31;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SERIAL_HIGH = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SERIAL_LOW  = 2'd3;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd165;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd90;
    localparam logic [7:0] SERIAL_HIGH_RST = 8'd4;
    localparam logic [7:0] SERIAL_LOW_RST  = 8'd119;

    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [3:0]              field_id_t;
    typedef logic [VALUE_W-1:0]      field_value_t;

    // frame request handed from the parser to the queue
    typedef struct packed {
        logic     valid;
        payload_t payload;
    } frame_req_t;

    // queue status seen by the parser
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tfd_front.sv =====
// frame parser: header match, payload capture and checksum test
`default_nettype none
`include "telemetry_frame_decoder_defines.svh"
module tfd_front
    import tfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire queue_status_t         q_status,
    output frame_req_t                 push_req
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_SER_HI = 3'd2;
    localparam logic [2:0] PH_SER_LO = 3'd3;
    localparam logic [2:0] PH_TYPE   = 3'd4;
    localparam logic [2:0] PH_SIZE   = 3'd5;
    localparam logic [2:0] PH_BODY   = 3'd6;

    localparam logic [4:0] CNT_CHECK_HI = 5'(PAYLOAD_LEN);
    localparam logic [4:0] CNT_CHECK_LO = 5'(PAYLOAD_LEN + 1);

    logic [7:0] sync_first_reg, sync_second_reg, serial_high_reg, serial_low_reg;
    logic [2:0] phase_reg, phase_next;
    logic [4:0] count_reg, count_next;
    logic [7:0] sum_lo_reg, sum_lo_next;
    logic [7:0] sum_hi_reg, sum_hi_next;
    payload_t   shift_reg, shift_next;
    logic [7:0] check_hi_reg, check_hi_next;

    logic       accept;
    logic       at_check_lo;
    logic [7:0] b;
    logic [7:0] add_lo, add_hi;
    logic [7:0] want_hi, want_lo;
    logic       match;

    assign b           = s_tdata;
    assign at_check_lo = (phase_reg == PH_BODY) && (count_reg == CNT_CHECK_LO);
    // only the final check byte can produce a request
    assign s_tready    = !(at_check_lo && q_status.full);
    assign accept      = s_tvalid && s_tready;

    assign add_lo  = sum_lo_reg + b;
    assign add_hi  = sum_hi_reg + add_lo;
    assign want_hi = sum_lo_reg - sum_hi_reg;
    assign want_lo = sum_hi_reg - {sum_lo_reg[6:0], 1'b0};
    assign match   = (want_hi == check_hi_reg) && (want_lo == b);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_lo_next   = sum_lo_reg;
        sum_hi_next   = sum_hi_reg;
        shift_next    = shift_reg;
        check_hi_next = check_hi_reg;
        push_req.valid   = 1'b0;
        push_req.payload = shift_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    if (b == sync_second_reg) begin
                        sum_lo_next = add_lo;
                        sum_hi_next = add_hi;
                        phase_next  = PH_SER_HI;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SER_HI: begin
                    if (b == serial_high_reg) begin
                        sum_lo_next = add_lo;
                        sum_hi_next = add_hi;
                        phase_next  = PH_SER_LO;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SER_LO: begin
                    if (b == serial_low_reg) begin
                        sum_lo_next = add_lo;
                        sum_hi_next = add_hi;
                        phase_next  = PH_TYPE;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_TYPE, PH_SIZE: begin
                    sum_lo_next = add_lo;
                    sum_hi_next = add_hi;
                    phase_next  = phase_reg + 3'd1;
                    count_next  = '0;
                end
                PH_BODY: begin
                    if (count_reg < CNT_CHECK_HI) begin
                        // newest byte enters at the low end
                        shift_next  = {shift_reg[PAYLOAD_BITS-9:0], b};
                        sum_lo_next = add_lo;
                        sum_hi_next = add_hi;
                        count_next  = count_reg + 5'd1;
                    end else if (count_reg == CNT_CHECK_HI) begin
                        check_hi_next = b;
                        count_next    = count_reg + 5'd1;
                    end else begin
                        push_req.valid = match;
                        phase_next     = PH_HUNT;
                        count_next     = '0;
                    end
                end
                default: begin
                    // hunting, also for the unused phase code
                    count_next = '0;
                    if (b == sync_first_reg) begin
                        sum_lo_next = b;
                        sum_hi_next = b;
                        phase_next  = PH_SYNC2;
                    end else begin
                        sum_lo_next = '0;
                        sum_hi_next = '0;
                        phase_next  = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            count_reg       <= '0;
            sum_lo_reg      <= '0;
            sum_hi_reg      <= '0;
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            serial_high_reg <= SERIAL_HIGH_RST;
            serial_low_reg  <= SERIAL_LOW_RST;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                    REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                    REG_SERIAL_HIGH: serial_high_reg <= cfg_wdata;
                    REG_SERIAL_LOW:  serial_low_reg  <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        check_hi_reg <= check_hi_next;
    end

    `TFD_ASSERT(a_ready_only_drops_on_check, s_tready || at_check_lo,
        "input stalled outside the final check byte")

endmodule
`default_nettype wire

// ===== rtl/core/tfd_queue.sv =====
// short frame queue between the parser and the result sequencer
`default_nettype none
`include "telemetry_frame_decoder_defines.svh"
module tfd_queue
    import tfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_req_t push_req,
    input  wire logic       pop,
    output queue_status_t   status,
    output payload_t        head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    payload_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic       push;

    assign push         = push_req.valid;
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req.payload;
        end
    end

    `TFD_ASSERT(a_no_push_when_full, !(push && status.full), "frame pushed into a full queue")
    `TFD_ASSERT(a_no_pop_when_empty, !(pop && status.empty), "frame popped from an empty queue")
    `TFD_ASSERT(a_count_in_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// ===== rtl/core/tfd_back.sv =====
// result sequencer: scales the 14 telemetry fields of a queued frame
`default_nettype none
`include "telemetry_frame_decoder_defines.svh"
module tfd_back
    import tfd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire queue_status_t          q_status,
    input  wire payload_t               head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    localparam field_id_t LAST_ID = 4'(FIELD_COUNT - 1);

    function automatic logic [7:0] pbyte(payload_t p, int k);
        return p[(PAYLOAD_LEN - 1 - k) * 8 +: 8];
    endfunction

    function automatic field_value_t scale(payload_t p, field_id_t id);
        logic [15:0]  pct_t;
        logic [15:0]  pct_q;
        logic [31:0]  fuel;
        logic [23:0]  etime;
        logic [7:0]   air;
        field_value_t v;
        // floor(n/255) as ((n+1) + ((n+1)>>8)) >> 8 for the small range used here
        pct_t = 16'(pbyte(p, 0)) * 16'd100 + 16'd1;
        pct_q = (pct_t + (pct_t >> 8)) >> 8;
        fuel  = {pbyte(p, 14), pbyte(p, 15), pbyte(p, 16), pbyte(p, 17)};
        etime = {pbyte(p, 18), pbyte(p, 19), pbyte(p, 20)};
        air   = pbyte(p, 11);
        unique case (id)
            4'd0:  v = VALUE_W'(pct_q);
            4'd1:  v = VALUE_W'(pbyte(p, 1)) * VALUE_W'(50);
            4'd2:  v = VALUE_W'(pbyte(p, 2) >> 4);
            4'd3:  v = VALUE_W'({pbyte(p, 2) & 8'h0F, pbyte(p, 3)});
            4'd4:  v = VALUE_W'({pbyte(p, 4), pbyte(p, 5)}) * VALUE_W'(50);
            4'd5:  v = VALUE_W'(pbyte(p, 6)) - VALUE_W'(10);
            4'd6:  v = VALUE_W'(pbyte(p, 7));
            4'd7:  v = VALUE_W'({pbyte(p, 8), pbyte(p, 9), 1'b0});
            4'd8:  v = VALUE_W'(pbyte(p, 10));
            4'd9:  v = {{(VALUE_W - 8){air[7]}}, air};
            4'd10: v = VALUE_W'({pbyte(p, 12), pbyte(p, 13)}) * VALUE_W'(20);
            // fuel used saturates at the largest 30-bit value
            4'd11: v = (fuel[31:30] != 2'b00) ? VALUE_W'(32'h3FFF_FFFF) : fuel[VALUE_W-1:0];
            4'd12: v = VALUE_W'(etime) * VALUE_W'(60);
            4'd13: v = VALUE_W'(pbyte(p, 21));
            default: v = '0;
        endcase
        return v;
    endfunction

    field_id_t    cnt_reg;
    logic         valid_reg;
    field_id_t    id_reg;
    field_value_t value_reg;
    logic         last_reg;
    logic         load;

    assign load = !q_status.empty && (!valid_reg || m_tready);
    assign pop  = load && (cnt_reg == LAST_ID);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                cnt_reg   <= (cnt_reg == LAST_ID) ? '0 : cnt_reg + 4'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg    <= cnt_reg;
            value_reg <= scale(head, cnt_reg);
            last_reg  <= (cnt_reg == LAST_ID);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VALUE_W - 4)'(0), value_reg, id_reg};
    assign m_tlast  = last_reg;

    `TFD_ASSERT(a_last_on_final_field, !(valid_reg && last_reg) || (id_reg == LAST_ID),
        "last flag on a field other than the final one")

endmodule
`default_nettype wire

// ===== rtl/core/telemetry_frame_decoder.sv =====
// Telemetry frame decoder top level.
// Bytes arrive on the s_ stream (s_tdata[7:0] = rx_byte), one per request.
// The parser hunts for two sync bytes and two serial bytes (set through the
// cfg_ write port), skips type and size, takes 24 payload bytes and checks
// the 16-bit big-endian Fletcher-style check word that follows.
// A good frame produces 14 results on the m_ stream: m_tdata[3:0] field id,
// m_tdata[34:4] scaled value, m_tlast on field 13.
// Throughput: one byte per cycle in and one result per cycle out, barring stalls.
// With an empty queue the first result passes from the taken check byte through
// the queue write, which lands on the accepting edge, and the output register
// load on the next; the rest follow each cycle while m_tready is high.
// The frame queue holds QUEUE_DEPTH_P frames; s_tready drops only on the
// final check byte while the queue is full, which a stalled receiver can cause.
// A stalled receiver holds the current result on m_tdata; the parser keeps
// taking bytes until the queue fills.
// Reset loads the register defaults, starts the hunt and empties the queue.
`default_nettype none
`include "telemetry_frame_decoder_defines.svh"
module telemetry_frame_decoder
    import tfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [3:0] field_id, [34:4] field_value
    output logic                        m_tlast
);

    frame_req_t    push_req;
    queue_status_t q_status;
    payload_t      head;
    logic          pop;

    tfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push_req  (push_req)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_req (push_req),
        .pop      (pop),
        .status   (q_status),
        .head     (head)
    );

    tfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
